/* sv/xst_pkg.sv */
// Package: shared types and constants for the XML SAX tokenizer.
`timescale 1ns / 1ps
package xst_pkg;

  typedef enum logic [3:0] {
    EV_TEXT    = 4'd0,
    EV_OPEN    = 4'd1,
    EV_ATTRIB  = 4'd2,
    EV_CLOSE   = 4'd3,
    EV_PI      = 4'd4,
    EV_COMMENT = 4'd5,
    EV_CDATA   = 4'd6,
    EV_DTPART  = 4'd7,
    EV_DTEND   = 4'd8,
    EV_DONE    = 4'd9,
    EV_ERROR   = 4'd10
  } event_e;

  typedef enum logic [4:0] {
    S_READY, S_LT, S_OPEN_NAME, S_IN_TAG, S_ANAME, S_AEQ, S_AQUOTE,
    S_AVALUE, S_WAIT_GT, S_SLASH, S_CLOSE_NAME, S_CLOSE_GT, S_KW_XML,
    S_BANG, S_KW_DASH, S_KW_DOCTYPE, S_KW_CDATA, S_DT, S_DT_NAME,
    S_DT_STRING, S_PI, S_COMMENT, S_CDATA, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    K_TAG, K_SELF, K_XML, K_CDATA, K_DOCTYPE
  } kind_e;

  // Final-result flag on top of one event slot.
  localparam int unsigned OUT_W = 1 + 4 + 4 * 32 + 1;

  // One event slot as it leaves the parser.
  typedef struct packed {
    event_e      kind;
    logic [31:0] span_start;
    logic [31:0] span_length;
    logic [31:0] value_start;
    logic [31:0] value_length;
    logic        ws_only;
  } event_t;

  // Queue entry between the parser and the output side.
  typedef struct packed {
    logic   [1:0] cnt;
    event_t       ev0;
    event_t       ev1;
  } qentry_t;

  function automatic logic is_space(input logic [15:0] u);
    return (u == 16'h20) || (u >= 16'h09 && u <= 16'h0D);
  endfunction

  function automatic logic is_alpha(input logic [15:0] u);
    return (u >= 16'h41 && u <= 16'h5A) || (u >= 16'h61 && u <= 16'h7A) || (u >= 16'h80);
  endfunction

  function automatic logic name_start(input logic [15:0] u);
    return is_alpha(u) || u == 16'h5F || u == 16'h3A;
  endfunction

  function automatic logic name_char(input logic [15:0] u);
    return name_start(u) || (u >= 16'h30 && u <= 16'h39) || u == 16'h2D || u == 16'h2E;
  endfunction

  function automatic logic [15:0] kw_dt(input logic [2:0] k);
    case (k)
      3'd0: return 16'h44;
      3'd1: return 16'h4F;
      3'd2: return 16'h43;
      3'd3: return 16'h54;
      3'd4: return 16'h59;
      3'd5: return 16'h50;
      3'd6: return 16'h45;
      default: return 16'h0;
    endcase
  endfunction

  function automatic logic [15:0] kw_cd(input logic [2:0] k);
    case (k)
      3'd0: return 16'h5B;
      3'd1: return 16'h43;
      3'd2: return 16'h44;
      3'd3: return 16'h41;
      3'd4: return 16'h54;
      3'd5: return 16'h41;
      3'd6: return 16'h5B;
      default: return 16'h0;
    endcase
  endfunction

  function automatic logic [15:0] kw_xm(input logic [1:0] k);
    case (k)
      2'd0: return 16'h78;
      2'd1: return 16'h6D;
      2'd2: return 16'h6C;
      default: return 16'h0;
    endcase
  endfunction

endpackage

/* sv/xml_sax_tokenizer.sv */
// Top level: XML SAX tokenizer with a stream input and an event stream output.
`timescale 1ns / 1ps
// Latency: events pass through the registered event queue before they appear on the master side.
// Throughput: one code unit per cycle while the event queue has room; a unit that causes two
//   events needs two output transactions, and a four-entry event queue absorbs such bursts.
// Reset: asynchronous, active low; parser returns to ready at offset zero and
//   the event queue empties.
module xml_sax_tokenizer #(
  parameter int unsigned POS_BITS          = 32,
  parameter int unsigned DEPTH_BITS        = 16,
  parameter int unsigned MAX_DOCTYPE_PARTS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // code_unit
  input  logic         s_axis_tlast,   // last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // event_kind, span_start, span_length,
                                       // value_start, value_length, whitespace_only
  output logic         m_axis_tlast    // final_result
);

  logic             push, room;
  xst_pkg::qentry_t entry;
  logic [xst_pkg::OUT_W-1:0] bus;
  xst_pkg::event_t  ev;

  // Accept whenever the queue has space for one more entry.
  assign s_axis_tready = room;

  xst_parser #(
    .POS_BITS(POS_BITS), .DEPTH_BITS(DEPTH_BITS), .MAX_DOCTYPE_PARTS(MAX_DOCTYPE_PARTS)
  ) u_parser (
    .clk_i(clk_i), .rst_ni(rst_ni), .step_i(s_axis_tvalid && room),
    .unit_i(s_axis_tdata), .last_i(s_axis_tlast), .push_o(push), .entry_o(entry)
  );

  xst_backend u_backend (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .entry_i(entry), .room_o(room),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .data_o(bus)
  );

  // Pack the event fields, event_kind in the lowest bits, padded to 136 bits.
  assign ev = bus[xst_pkg::OUT_W-2:0];
  assign m_axis_tlast = bus[xst_pkg::OUT_W-1];
  assign m_axis_tdata = {3'b000, ev.ws_only, ev.value_length, ev.value_start,
                         ev.span_length, ev.span_start, ev.kind};

endmodule

/* sv/xst_parser.sv */
// Front part: tokenizer state machine, one code unit per cycle while stepped, emits up to two events per unit.
`timescale 1ns / 1ps
module xst_parser #(
  parameter int unsigned POS_BITS          = 32,
  parameter int unsigned DEPTH_BITS        = 16,
  parameter int unsigned MAX_DOCTYPE_PARTS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [15:0]      unit_i,
  input  logic             last_i,
  output logic             push_o,
  output xst_pkg::qentry_t entry_o
);

  localparam logic [DEPTH_BITS-1:0] DepthLimit = {DEPTH_BITS{1'b1}};
  localparam logic [2:0] MaxParts = 3'(MAX_DOCTYPE_PARTS);

  xst_pkg::state_e st_q, st_d;
  xst_pkg::kind_e  kind_q, kind_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  logic [POS_BITS-1:0] pos_q, text_q, text_d, nms_q, nms_d, nme_q, nme_d;
  logic [POS_BITS-1:0] ams_q, ams_d, ame_q, ame_d, dms_q, dms_d;
  logic [15:0] quote_q, quote_d;
  logic        allsp_q, allsp_d, err_q, err_d;
  logic [2:0]  parts_q, parts_d, kw_q, kw_d;
  logic [1:0]  th_q, th_d;

  logic [POS_BITS-1:0] p, nx;
  logic [1:0] cnt;
  xst_pkg::event_t ev [2];

  function automatic logic [31:0] w32(input logic [POS_BITS-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[31:0];
  endfunction

  function automatic xst_pkg::event_t mk(input xst_pkg::event_e k,
      input logic [POS_BITS-1:0] s, input logic [POS_BITS-1:0] l,
      input logic [POS_BITS-1:0] vs, input logic [POS_BITS-1:0] vl, input logic ws);
    xst_pkg::event_t e;
    e.kind = k;
    e.span_start = w32(s);
    e.span_length = w32(l);
    e.value_start = w32(vs);
    e.value_length = w32(vl);
    e.ws_only = ws;
    return e;
  endfunction

  always_comb begin
    logic fail, part_now, again;
    logic [15:0] u, f;
    xst_pkg::event_t ne;
    logic put_en;
    st_d = st_q; kind_d = kind_q; depth_d = depth_q; text_d = text_q;
    nms_d = nms_q; nme_d = nme_q; ams_d = ams_q; ame_d = ame_q; dms_d = dms_q;
    quote_d = quote_q; allsp_d = allsp_q; err_d = err_q; parts_d = parts_q;
    kw_d = kw_q; th_d = th_q;
    u = unit_i;
    f = u;
    p = pos_q;
    nx = pos_q + 1'b1;
    cnt = 2'd0;
    ev[0] = mk(xst_pkg::EV_TEXT, '0, '0, '0, '0, 1'b0);
    ev[1] = ev[0];
    ne = ev[0];
    fail = 1'b0;
    part_now = 1'b0;
    // A state hands the same unit on to the next state at most once; two passes cover it.
    for (int pass = 0; pass < 2; pass++) begin
      again = 1'b0;
      put_en = 1'b0;
      case (st_d)
        xst_pkg::S_READY: begin
          if (u == 16'h3C) begin
            if (text_d != p) begin
              put_en = 1'b1;
              ne = mk(xst_pkg::EV_TEXT, text_d, p - text_d, '0, '0, allsp_d);
            end
            st_d = xst_pkg::S_LT; text_d = p; allsp_d = 1'b1;
          end else if (!xst_pkg::is_space(u)) allsp_d = 1'b0;
        end
        xst_pkg::S_LT: begin
          if (xst_pkg::name_start(u)) begin
            st_d = xst_pkg::S_OPEN_NAME; nms_d = p;
          end else if (u == 16'h2F) st_d = xst_pkg::S_SLASH;
          else if (u == 16'h3F) begin
            st_d = xst_pkg::S_KW_XML; kw_d = '0; dms_d = nx;
          end else if (u == 16'h21) st_d = xst_pkg::S_BANG;
          else if (!xst_pkg::is_space(u)) fail = 1'b1;
        end
        xst_pkg::S_OPEN_NAME: begin
          if (!xst_pkg::name_char(u)) begin
            nme_d = p;
            if (depth_d == DepthLimit) fail = 1'b1;
            else begin
              depth_d = depth_d + 1'b1; kind_d = xst_pkg::K_TAG;
              put_en = 1'b1;
              ne = mk(xst_pkg::EV_OPEN, nms_d, p - nms_d, '0, '0, 1'b0);
              st_d = xst_pkg::S_IN_TAG; again = 1'b1;
            end
          end
        end
        xst_pkg::S_IN_TAG: begin
          if (xst_pkg::is_space(u)) begin
          end else if (xst_pkg::is_alpha(u) || u == 16'h5F) begin
            ams_d = p; st_d = xst_pkg::S_ANAME;
          end else if (kind_d == xst_pkg::K_TAG && u == 16'h2F) begin
            kind_d = xst_pkg::K_SELF; st_d = xst_pkg::S_WAIT_GT;
          end else if (kind_d == xst_pkg::K_TAG && u == 16'h3E) begin
            st_d = xst_pkg::S_READY; text_d = nx; allsp_d = 1'b1;
          end else if (kind_d == xst_pkg::K_XML && u == 16'h3F) st_d = xst_pkg::S_WAIT_GT;
          else fail = 1'b1;
        end
        xst_pkg::S_ANAME: begin
          if (!xst_pkg::name_char(u)) begin
            ame_d = p; st_d = xst_pkg::S_AEQ; again = 1'b1;
          end
        end
        xst_pkg::S_AEQ: begin
          if (xst_pkg::is_space(u)) begin
          end else if (u != 16'h3D) fail = 1'b1;
          else st_d = xst_pkg::S_AQUOTE;
        end
        xst_pkg::S_AQUOTE: begin
          if (xst_pkg::is_space(u)) begin
          end else if (u != 16'h27 && u != 16'h22) fail = 1'b1;
          else begin
            quote_d = u; dms_d = nx; st_d = xst_pkg::S_AVALUE;
          end
        end
        xst_pkg::S_AVALUE: begin
          if (u == quote_d) begin
            put_en = 1'b1;
            ne = mk(xst_pkg::EV_ATTRIB, ams_d, ame_d - ams_d, dms_d, p - dms_d, 1'b0);
            st_d = xst_pkg::S_IN_TAG;
          end
        end
        xst_pkg::S_WAIT_GT: begin
          if (u == 16'h3E) begin
            st_d = xst_pkg::S_READY; text_d = nx; allsp_d = 1'b1;
            if (kind_d == xst_pkg::K_SELF) begin
              if (depth_d != '0) depth_d = depth_d - 1'b1;
              put_en = 1'b1;
              ne = mk(xst_pkg::EV_CLOSE, nms_d, nme_d - nms_d, '0, '0, 1'b0);
            end
          end
        end
        xst_pkg::S_SLASH: begin
          if (!xst_pkg::name_start(u)) fail = 1'b1;
          else begin
            st_d = xst_pkg::S_CLOSE_NAME; nms_d = p;
          end
        end
        xst_pkg::S_CLOSE_NAME: begin
          if (!xst_pkg::name_char(u)) begin
            nme_d = p; st_d = xst_pkg::S_CLOSE_GT; again = 1'b1;
          end
        end
        xst_pkg::S_CLOSE_GT: begin
          if (u == 16'h3E) begin
            if (depth_d == '0) fail = 1'b1;
            else begin
              depth_d = depth_d - 1'b1;
              st_d = xst_pkg::S_READY; text_d = nx; allsp_d = 1'b1;
              put_en = 1'b1;
              ne = mk(xst_pkg::EV_CLOSE, nms_d, nme_d - nms_d, '0, '0, 1'b0);
            end
          end else if (!xst_pkg::is_space(u)) fail = 1'b1;
        end
        xst_pkg::S_KW_XML: begin
          f = (u >= 16'h41 && u <= 16'h5A) ? u + 16'h20 : u;
          if (kw_d < 3'd3 && f == xst_pkg::kw_xm(kw_d[1:0])) kw_d = kw_d + 1'b1;
          else if (kw_d >= 3'd3 && xst_pkg::is_space(u)) begin
            kind_d = xst_pkg::K_XML; st_d = xst_pkg::S_IN_TAG;
          end else begin
            st_d = xst_pkg::S_PI; th_d = '0; again = 1'b1;
          end
        end
        xst_pkg::S_BANG: begin
          if (u == 16'h2D) st_d = xst_pkg::S_KW_DASH;
          else if (u == 16'h44) begin
            st_d = xst_pkg::S_KW_DOCTYPE; kw_d = 3'd1;
          end else if (u == 16'h5B) begin
            st_d = xst_pkg::S_KW_CDATA; kw_d = 3'd1;
          end else fail = 1'b1;
        end
        xst_pkg::S_KW_DASH: begin
          if (u != 16'h2D) fail = 1'b1;
          else begin
            st_d = xst_pkg::S_COMMENT; dms_d = nx; th_d = '0;
          end
        end
        xst_pkg::S_KW_DOCTYPE: begin
          if (kw_d != 3'd7) begin
            if (u != xst_pkg::kw_dt(kw_d)) fail = 1'b1;
            else kw_d = kw_d + 1'b1;
          end else if (!xst_pkg::is_space(u)) fail = 1'b1;
          else begin
            kind_d = xst_pkg::K_DOCTYPE; parts_d = '0; st_d = xst_pkg::S_DT;
          end
        end
        xst_pkg::S_KW_CDATA: begin
          if (kw_d == 3'd7 || u != xst_pkg::kw_cd(kw_d)) fail = 1'b1;
          else begin
            kw_d = kw_d + 1'b1;
            if (kw_d == 3'd7) begin
              kind_d = xst_pkg::K_CDATA; st_d = xst_pkg::S_CDATA;
              dms_d = nx; th_d = '0;
            end
          end
        end
        xst_pkg::S_DT: begin
          if (xst_pkg::is_space(u)) begin
          end else if (u == 16'h3E) begin
            if (!(part_now && last_i)) begin
              put_en = 1'b1; ne = mk(xst_pkg::EV_DTEND, '0, '0, '0, '0, 1'b0);
            end
            st_d = xst_pkg::S_READY; text_d = nx; allsp_d = 1'b1;
          end else if (parts_d < 3'd2) begin
            if (!(xst_pkg::is_alpha(u) || u == 16'h5F)) fail = 1'b1;
            else begin
              st_d = xst_pkg::S_DT_NAME; dms_d = p;
            end
          end else if (u != 16'h22 || parts_d >= MaxParts) fail = 1'b1;
          else begin
            st_d = xst_pkg::S_DT_STRING; dms_d = nx;
          end
        end
        xst_pkg::S_DT_NAME: begin
          if (!xst_pkg::name_char(u)) begin
            put_en = 1'b1;
            ne = mk(xst_pkg::EV_DTPART, dms_d, p - dms_d, '0, '0, 1'b0);
            if (parts_d != 3'd7) parts_d = parts_d + 1'b1;
            part_now = 1'b1; st_d = xst_pkg::S_DT; again = 1'b1;
          end
        end
        xst_pkg::S_DT_STRING: begin
          if (u == 16'h22) begin
            put_en = 1'b1;
            ne = mk(xst_pkg::EV_DTPART, dms_d, p - dms_d, '0, '0, 1'b0);
            if (parts_d != 3'd7) parts_d = parts_d + 1'b1;
            st_d = xst_pkg::S_DT;
          end
        end
        xst_pkg::S_PI: begin
          if (th_d != '0 && u == 16'h3E) begin
            put_en = 1'b1;
            ne = mk(xst_pkg::EV_PI, dms_d, p - 1'b1 - dms_d, '0, '0, 1'b0);
            st_d = xst_pkg::S_READY; text_d = nx; allsp_d = 1'b1;
          end else th_d = (u == 16'h3F) ? 2'd1 : 2'd0;
        end
        xst_pkg::S_COMMENT, xst_pkg::S_CDATA: begin
          if (th_d == 2'd2 && u == 16'h3E) begin
            put_en = 1'b1;
            ne = mk((st_d == xst_pkg::S_COMMENT) ? xst_pkg::EV_COMMENT : xst_pkg::EV_CDATA,
                    dms_d, p - 2'd2 - dms_d, '0, '0, 1'b0);
            st_d = xst_pkg::S_READY; text_d = nx; allsp_d = 1'b1;
          end else if (u == ((st_d == xst_pkg::S_COMMENT) ? 16'h2D : 16'h5D)) begin
            if (th_d != 2'd2) th_d = th_d + 1'b1;
          end else th_d = '0;
        end
        default: fail = 1'b1;
      endcase
      if (put_en && cnt != 2'd2) begin
        ev[cnt[0]] = ne;
        cnt = cnt + 1'b1;
      end
      if (!again || fail) break;
    end
    if (fail) begin
      err_d = 1'b1;
      if (cnt != 2'd2) begin
        ev[cnt[0]] = mk(xst_pkg::EV_ERROR, p, '0, '0, '0, 1'b0);
        cnt = cnt + 1'b1;
      end
    end else if (last_i) begin
      if (depth_d != '0 || st_d != xst_pkg::S_READY) begin
        err_d = 1'b1;
        if (cnt != 2'd2) begin
          ev[cnt[0]] = mk(xst_pkg::EV_ERROR, p, '0, '0, '0, 1'b0);
          cnt = cnt + 1'b1;
        end
      end else begin
        st_d = xst_pkg::S_DONE;
        if (cnt != 2'd2) begin
          ev[cnt[0]] = mk(xst_pkg::EV_DONE, '0, nx, '0, '0, 1'b0);
          cnt = cnt + 1'b1;
        end
      end
    end
  end

  wire active = step_i && !err_q && st_q != xst_pkg::S_DONE;

  assign push_o = active && cnt != 2'd0;
  assign entry_o = '{cnt: cnt, ev0: ev[0], ev1: ev[1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= xst_pkg::S_READY; kind_q <= xst_pkg::K_TAG; depth_q <= '0; pos_q <= '0;
      text_q <= '0; nms_q <= '0; nme_q <= '0; ams_q <= '0; ame_q <= '0; dms_q <= '0;
      quote_q <= '0; allsp_q <= 1'b1; err_q <= 1'b0; parts_q <= '0; kw_q <= '0;
      th_q <= '0;
    end else if (active) begin
      st_q <= st_d; kind_q <= kind_d; depth_q <= depth_d; pos_q <= nx;
      text_q <= text_d; nms_q <= nms_d; nme_q <= nme_d; ams_q <= ams_d; ame_q <= ame_d;
      dms_q <= dms_d; quote_q <= quote_d; allsp_q <= allsp_d; err_q <= err_d;
      parts_q <= parts_d; kw_q <= kw_d; th_q <= th_d;
    end
  end

endmodule

/* sv/xst_backend.sv */
// Back part: event queue and serializer that delivers one event per transaction.
`timescale 1ns / 1ps
module xst_backend (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  xst_pkg::qentry_t          entry_i,
  output logic                      room_o,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [xst_pkg::OUT_W-1:0] data_o
);

  localparam int unsigned Depth = 4;

  xst_pkg::qentry_t mem_q [Depth];
  logic [1:0] wr_q, rd_q;
  logic [2:0] used_q;
  logic       sub_q;
  xst_pkg::qentry_t head;
  xst_pkg::event_t  cur;
  logic pop, fin;

  assign head    = mem_q[rd_q];
  assign cur     = sub_q ? head.ev1 : head.ev0;
  assign fin     = sub_q || head.cnt == 2'd1;
  assign valid_o = used_q != 3'd0;
  assign data_o  = {fin, cur};
  assign pop     = valid_o && ready_i && fin;
  // Accept when a slot is free or the head entry leaves in this cycle.
  assign room_o  = used_q < 3'(Depth) || pop;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; used_q <= '0; sub_q <= 1'b0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      used_q <= used_q + 3'(push_i) - 3'(pop);
      if (valid_o && ready_i) sub_q <= !fin;
    end
  end

endmodule

/* dv/tb_xml_sax_tokenizer.sv */
// Testbench: drives XML documents into the tokenizer and checks its events.
`timescale 1ns / 1ps
module tb_xml_sax_tokenizer;

  localparam logic [15:0] CH_LT = 16'h3C, CH_GT = 16'h3E, CH_SL = 16'h2F, CH_QM = 16'h3F;
  localparam logic [15:0] CH_BANG = 16'h21, CH_EQ = 16'h3D, CH_DASH = 16'h2D;
  localparam logic [15:0] CH_LB = 16'h5B, CH_RB = 16'h5D, CH_DQ = 16'h22, CH_SQ = 16'h27;
  localparam logic [15:0] CH_US = 16'h5F, CH_SP = 16'h20;
  localparam int DOC_UNITS = 1750;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    xst_pkg::event_e kind;
    logic [31:0]     span_start;
    logic [31:0]     span_len;
    logic [31:0]     val_start;
    logic [31:0]     val_len;
    logic            ws_only;
    logic            fin;
  } tok_event_t;

  typedef struct {
    logic [15:0]     u;
    bit              last;
    bit              chk;
    xst_pkg::event_e k;
  } doc_unit_t;

  typedef struct {
    logic [15:0]     u;
    bit              chk;
    xst_pkg::event_e k;
  } row_t;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [15:0]  s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [135:0] m_axis_tdata;

  xml_sax_tokenizer dut (.*);

  // Parser state of the predictor.
  xst_pkg::state_e pst;
  xst_pkg::kind_e  ekind;
  logic [15:0] depth, qch;
  logic [31:0] pos, tmark, nms, nme, ams, ame, dms;
  logic [2:0]  dparts, kidx;
  logic [1:0]  thist;
  bit          allsp, err_seen;
  string       kw_doctype = "DOCTYPE", kw_cdata = "[CDATA[", kw_xml = "xml";

  tok_event_t  burst[$];
  tok_event_t  events_due[$];
  doc_unit_t   doc_q[$];
  int          errors, sent_idx, taken_idx, idle_cycles, snd_pct, rcv_pct;

  // Clock; the stimulus runs in phases that stall none, the sender, the receiver or both.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit ws_u(logic [15:0] u);
    return u == CH_SP || (u >= 16'h09 && u <= 16'h0D);
  endfunction
  function automatic bit letter_u(logic [15:0] u);
    return (u >= 16'h41 && u <= 16'h5A) || (u >= 16'h61 && u <= 16'h7A) || u >= 16'h80;
  endfunction
  function automatic bit nstart_u(logic [15:0] u);
    return letter_u(u) || u == CH_US || u == 16'h3A;
  endfunction
  function automatic bit nchar_u(logic [15:0] u);
    return nstart_u(u) || (u >= 16'h30 && u <= 16'h39) || u == CH_DASH || u == 16'h2E;
  endfunction

  function automatic void add_event(xst_pkg::event_e k, logic [31:0] ss, logic [31:0] sl,
                                    logic [31:0] vs, logic [31:0] vl, bit ws);
    if (burst.size() < 2) burst.push_back('{k, ss, sl, vs, vl, ws, 1'b0});
  endfunction

  function automatic void go_ready(logic [31:0] nx);
    pst = xst_pkg::S_READY;
    tmark = nx;
    allsp = 1'b1;
  endfunction

  // Advance the parser by one unit; return 1 on a syntax error.
  function automatic bit parse_unit(logic [15:0] u, logic [31:0] p, bit last);
    logic [31:0] nx;
    logic [15:0] f, mk;
    logic [2:0]  k;
    bit          part_now, again;
    nx = p + 1;
    part_now = 0;
    do begin
      again = 0;
      case (pst)
        xst_pkg::S_READY: begin
          if (u == CH_LT) begin
            if (tmark != p) add_event(xst_pkg::EV_TEXT, tmark, p - tmark, 0, 0, allsp);
            pst = xst_pkg::S_LT;
            tmark = p;
            allsp = 1'b1;
          end else if (!ws_u(u)) allsp = 1'b0;
          return 0;
        end
        xst_pkg::S_LT: begin
          if (nstart_u(u)) begin
            pst = xst_pkg::S_OPEN_NAME;
            nms = p;
          end else if (u == CH_SL) pst = xst_pkg::S_SLASH;
          else if (u == CH_QM) begin
            pst = xst_pkg::S_KW_XML;
            kidx = 0;
            dms = nx;
          end else if (u == CH_BANG) pst = xst_pkg::S_BANG;
          else if (!ws_u(u)) return 1;
          return 0;
        end
        xst_pkg::S_OPEN_NAME: begin
          if (nchar_u(u)) return 0;
          nme = p;
          if (depth == 16'hFFFF) return 1;
          depth++;
          ekind = xst_pkg::K_TAG;
          add_event(xst_pkg::EV_OPEN, nms, p - nms, 0, 0, 0);
          pst = xst_pkg::S_IN_TAG;
          again = 1;
        end
        xst_pkg::S_IN_TAG: begin
          if (ws_u(u)) return 0;
          if (letter_u(u) || u == CH_US) begin
            ams = p;
            pst = xst_pkg::S_ANAME;
            return 0;
          end
          if (ekind == xst_pkg::K_TAG) begin
            if (u == CH_SL) begin
              ekind = xst_pkg::K_SELF;
              pst = xst_pkg::S_WAIT_GT;
              return 0;
            end
            if (u == CH_GT) begin
              go_ready(nx);
              return 0;
            end
          end else if (ekind == xst_pkg::K_XML && u == CH_QM) begin
            pst = xst_pkg::S_WAIT_GT;
            return 0;
          end
          return 1;
        end
        xst_pkg::S_ANAME: begin
          if (nchar_u(u)) return 0;
          ame = p;
          pst = xst_pkg::S_AEQ;
          again = 1;
        end
        xst_pkg::S_AEQ: begin
          if (ws_u(u)) return 0;
          if (u != CH_EQ) return 1;
          pst = xst_pkg::S_AQUOTE;
          return 0;
        end
        xst_pkg::S_AQUOTE: begin
          if (ws_u(u)) return 0;
          if (u != CH_SQ && u != CH_DQ) return 1;
          qch = u;
          dms = nx;
          pst = xst_pkg::S_AVALUE;
          return 0;
        end
        xst_pkg::S_AVALUE: begin
          if (u != qch) return 0;
          add_event(xst_pkg::EV_ATTRIB, ams, ame - ams, dms, p - dms, 0);
          pst = xst_pkg::S_IN_TAG;
          return 0;
        end
        xst_pkg::S_WAIT_GT: begin
          if (u == CH_GT) begin
            go_ready(nx);
            if (ekind == xst_pkg::K_SELF) begin
              if (depth > 0) depth--;
              add_event(xst_pkg::EV_CLOSE, nms, nme - nms, 0, 0, 0);
            end
          end
          return 0;
        end
        xst_pkg::S_SLASH: begin
          if (!nstart_u(u)) return 1;
          pst = xst_pkg::S_CLOSE_NAME;
          nms = p;
          return 0;
        end
        xst_pkg::S_CLOSE_NAME: begin
          if (nchar_u(u)) return 0;
          nme = p;
          pst = xst_pkg::S_CLOSE_GT;
          again = 1;
        end
        xst_pkg::S_CLOSE_GT: begin
          if (u == CH_GT) begin
            if (depth == 0) return 1;
            depth--;
            go_ready(nx);
            add_event(xst_pkg::EV_CLOSE, nms, nme - nms, 0, 0, 0);
            return 0;
          end
          return !ws_u(u);
        end
        xst_pkg::S_KW_XML: begin
          k = kidx;
          if (k < 3) begin
            f = (u >= 16'h41 && u <= 16'h5A) ? u + 16'h20 : u;
            if (f == 16'(kw_xml[k])) begin
              kidx = k + 1;
              return 0;
            end
          end else if (ws_u(u)) begin
            ekind = xst_pkg::K_XML;
            pst = xst_pkg::S_IN_TAG;
            return 0;
          end
          pst = xst_pkg::S_PI;
          thist = 0;
          again = 1;
        end
        xst_pkg::S_BANG: begin
          if (u == CH_DASH) pst = xst_pkg::S_KW_DASH;
          else if (u == 16'h44) begin
            pst = xst_pkg::S_KW_DOCTYPE;
            kidx = 1;
          end else if (u == CH_LB) begin
            pst = xst_pkg::S_KW_CDATA;
            kidx = 1;
          end else return 1;
          return 0;
        end
        xst_pkg::S_KW_DASH: begin
          if (u != CH_DASH) return 1;
          pst = xst_pkg::S_COMMENT;
          dms = nx;
          thist = 0;
          return 0;
        end
        xst_pkg::S_KW_DOCTYPE: begin
          k = kidx;
          if (k < 7) begin
            if (u != 16'(kw_doctype[k])) return 1;
            kidx = k + 1;
            return 0;
          end
          if (!ws_u(u)) return 1;
          ekind = xst_pkg::K_DOCTYPE;
          dparts = 0;
          pst = xst_pkg::S_DT;
          return 0;
        end
        xst_pkg::S_KW_CDATA: begin
          k = kidx;
          if (k == 7 || u != 16'(kw_cdata[k])) return 1;
          k++;
          kidx = k;
          if (k == 7) begin
            ekind = xst_pkg::K_CDATA;
            pst = xst_pkg::S_CDATA;
            dms = nx;
            thist = 0;
          end
          return 0;
        end
        xst_pkg::S_DT: begin
          if (ws_u(u)) return 0;
          if (u == CH_GT) begin
            // a name closed by the final '>' leaves the status to stand for the end
            if (!(part_now && last)) add_event(xst_pkg::EV_DTEND, 0, 0, 0, 0, 0);
            go_ready(nx);
            return 0;
          end
          if (dparts < 2) begin
            if (!(letter_u(u) || u == CH_US)) return 1;
            pst = xst_pkg::S_DT_NAME;
            dms = p;
            return 0;
          end
          if (u != CH_DQ || dparts >= 4) return 1;
          pst = xst_pkg::S_DT_STRING;
          dms = nx;
          return 0;
        end
        xst_pkg::S_DT_NAME: begin
          if (nchar_u(u)) return 0;
          add_event(xst_pkg::EV_DTPART, dms, p - dms, 0, 0, 0);
          if (dparts < 7) dparts++;
          part_now = 1;
          pst = xst_pkg::S_DT;
          again = 1;
        end
        xst_pkg::S_DT_STRING: begin
          if (u != CH_DQ) return 0;
          add_event(xst_pkg::EV_DTPART, dms, p - dms, 0, 0, 0);
          if (dparts < 7) dparts++;
          pst = xst_pkg::S_DT;
          return 0;
        end
        xst_pkg::S_PI: begin
          if (thist != 0 && u == CH_GT) begin
            add_event(xst_pkg::EV_PI, dms, (p - 1) - dms, 0, 0, 0);
            go_ready(nx);
          end else thist = (u == CH_QM) ? 2'd1 : 2'd0;
          return 0;
        end
        xst_pkg::S_COMMENT, xst_pkg::S_CDATA: begin
          mk = (pst == xst_pkg::S_COMMENT) ? CH_DASH : CH_RB;
          if (thist >= 2 && u == CH_GT) begin
            add_event((pst == xst_pkg::S_COMMENT) ? xst_pkg::EV_COMMENT : xst_pkg::EV_CDATA,
                      dms, (p - 2) - dms, 0, 0, 0);
            go_ready(nx);
          end else if (u == mk) thist = (thist < 2) ? thist + 2'd1 : 2'd2;
          else thist = 0;
          return 0;
        end
        default: return 1;
      endcase
    end while (again);
    return 0;
  endfunction

  // Predict the events of one accepted unit and queue them.
  function automatic void tokenize_unit(logic [15:0] u, bit last);
    logic [31:0] p;
    burst.delete();
    if (err_seen || pst == xst_pkg::S_DONE) return;
    p = pos;
    if (parse_unit(u, p, last)) begin
      err_seen = 1;
      add_event(xst_pkg::EV_ERROR, p, 0, 0, 0, 0);
    end else if (last) begin
      if (depth != 0 || pst != xst_pkg::S_READY) begin
        err_seen = 1;
        add_event(xst_pkg::EV_ERROR, p, 0, 0, 0, 0);
      end else begin
        pst = xst_pkg::S_DONE;
        add_event(xst_pkg::EV_DONE, 0, p + 1, 0, 0, 0);
      end
    end
    pos = p + 1;
    if (burst.size() > 0) burst[$].fin = 1'b1;
    foreach (burst[i]) events_due.push_back(burst[i]);
  endfunction

  // ---- document builder ----
  function automatic void put_u(logic [15:0] u);
    doc_q.push_back('{u, 0, 0, xst_pkg::EV_TEXT});
  endfunction
  function automatic void put_s(string s);
    foreach (s[i]) put_u(16'(s[i]));
  endfunction
  function automatic logic [15:0] any_but(logic [15:0] x);
    logic [15:0] v;
    do v = 16'($urandom_range(0, 65535)); while (v == x);
    return v;
  endfunction
  function automatic logic [15:0] rand_ws();
    case ($urandom_range(0, 5))
      0: return CH_SP;
      default: return 16'($urandom_range(9, 13));
    endcase
  endfunction
  function automatic void put_ws(int lo, int hi);
    repeat ($urandom_range(lo, hi)) put_u(rand_ws());
  endfunction
  function automatic logic [15:0] rand_letter();
    case ($urandom_range(0, 2))
      0: return 16'($urandom_range(16'h41, 16'h5A));
      1: return 16'($urandom_range(16'h61, 16'h7A));
      default: return 16'($urandom_range(16'h80, 16'hFFFF));
    endcase
  endfunction
  function automatic void put_name(bit elem);
    case ($urandom_range(0, 5))
      0: put_u(CH_US);
      1: put_u(elem ? 16'h3A : CH_US);
      default: put_u(rand_letter());
    endcase
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 5))
        0: put_u(16'($urandom_range(16'h30, 16'h39)));
        1: put_u(CH_DASH);
        2: put_u(16'h2E);
        default: put_u(rand_letter());
      endcase
    end
  endfunction
  function automatic void put_run(logic [15:0] stop, int hi);
    repeat ($urandom_range(0, hi)) put_u(any_but(stop));
  endfunction
  function automatic void put_open(bit self_close);
    logic [15:0] q;
    put_u(CH_LT);
    put_name(1);
    repeat ($urandom_range(0, 2)) begin
      put_ws(1, 2);
      put_u($urandom_range(0, 3) == 0 ? CH_US : rand_letter());
      put_name(0);
      put_ws(0, 1);
      put_u(CH_EQ);
      put_ws(0, 1);
      q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
      put_u(q);
      put_run(q, 6);
      put_u(q);
    end
    put_ws(0, 1);
    if (self_close) begin
      put_u(CH_SL);
      put_run(CH_GT, 2);   // strays before '>' are ignored
    end
    put_u(CH_GT);
  endfunction
  function automatic void put_close();
    put_u(CH_LT);
    put_u(CH_SL);
    put_name(1);
    put_ws(0, 2);
    put_u(CH_GT);
  endfunction
  function automatic void put_text();
    if ($urandom_range(0, 2) == 0) put_ws(1, 4);
    else repeat ($urandom_range(1, 8)) put_u(any_but(CH_LT));
  endfunction
  function automatic void put_doctype(bit end_here);
    int names;
    put_s("<!DOCTYPE");
    put_ws(1, 2);
    put_name(0);
    if (end_here) begin
      put_u(CH_GT);
      return;
    end
    names = $urandom_range(1, 2);
    if (names == 2) begin
      put_ws(1, 1);
      put_u(rand_letter());
      put_name(0);
      repeat ($urandom_range(0, 2)) begin
        put_ws(1, 1);
        put_u(CH_DQ);
        put_run(CH_DQ, 5);
        put_u(CH_DQ);
      end
    end
    put_ws(0, 1);
    put_u(CH_GT);
  endfunction
  function automatic void put_fragment(ref int open_tags);
    case ($urandom_range(0, 10))
      0, 1: put_text();
      2, 3: if (open_tags < 8) begin
        put_open(0);
        open_tags++;
      end
      4, 5: if (open_tags > 0) begin
        put_close();
        open_tags--;
      end
      6: put_open(1);
      7: begin
        put_s("<?");
        put_name(0);
        put_ws(0, 1);
        put_run(CH_QM, 6);
        put_s("?>");
      end
      8: begin
        put_s("<!--");
        put_run(CH_DASH, 6);
        put_s("-->");
      end
      9: begin
        put_s("<![CDATA[");
        put_run(CH_RB, 6);
        put_s("]]>");
      end
      default: begin
        if ($urandom_range(0, 1)) put_doctype(0);
        else begin
          put_u(CH_LT);
          put_u(CH_QM);
          put_u($urandom_range(0, 1) ? 16'h78 : 16'h58);
          put_u($urandom_range(0, 1) ? 16'h6D : 16'h4D);
          put_u($urandom_range(0, 1) ? 16'h6C : 16'h4C);
          put_ws(1, 1);
          put_s("v='1'");
          put_ws(0, 1);
          put_s("?>");
        end
      end
    endcase
  endfunction

  // Directed opening: space text, open, extreme units, close, comment, PI.
  row_t opening[] = '{
    '{CH_SP, 0, xst_pkg::EV_TEXT}, '{CH_LT, 1, xst_pkg::EV_TEXT},
    '{16'h72, 0, xst_pkg::EV_TEXT}, '{CH_GT, 1, xst_pkg::EV_OPEN},
    '{16'hFFFF, 0, xst_pkg::EV_TEXT}, '{16'h0000, 0, xst_pkg::EV_TEXT},
    '{CH_LT, 1, xst_pkg::EV_TEXT}, '{CH_SL, 0, xst_pkg::EV_TEXT},
    '{16'h72, 0, xst_pkg::EV_TEXT}, '{CH_GT, 1, xst_pkg::EV_CLOSE},
    '{CH_LT, 0, xst_pkg::EV_TEXT}, '{CH_BANG, 0, xst_pkg::EV_TEXT},
    '{CH_DASH, 0, xst_pkg::EV_TEXT}, '{CH_DASH, 0, xst_pkg::EV_TEXT},
    '{CH_DASH, 0, xst_pkg::EV_TEXT}, '{CH_DASH, 0, xst_pkg::EV_TEXT},
    '{CH_GT, 1, xst_pkg::EV_COMMENT}, '{CH_LT, 0, xst_pkg::EV_TEXT},
    '{CH_QM, 0, xst_pkg::EV_TEXT}, '{16'h70, 0, xst_pkg::EV_TEXT},
    '{CH_QM, 0, xst_pkg::EV_TEXT}, '{CH_GT, 1, xst_pkg::EV_PI}
  };

  function automatic void build_document();
    int open_tags;
    open_tags = 0;
    foreach (opening[i]) doc_q.push_back('{opening[i].u, 0, opening[i].chk, opening[i].k});
    while (doc_q.size() < DOC_UNITS) put_fragment(open_tags);
    case ($urandom_range(0, 3))
      0: begin   // clean end, maybe with trailing text
        repeat (open_tags) put_close();
        put_open(1);
        if ($urandom_range(0, 1)) put_text();
      end
      1: begin   // unclosed element at the end
        if (open_tags == 0) put_open(0);
      end
      2: begin   // bad unit after '<'
        put_u(CH_LT);
        put_u(CH_EQ);
      end
      default: begin   // doctype name closed by the final '>'
        repeat (open_tags) put_close();
        put_doctype(1);
      end
    endcase
    doc_q[$].last = 1;
    repeat (8) put_u(16'($urandom_range(0, 65535)));  // ignored after the end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Monitor: predict on input transactions, compare on output transactions.
  always @(posedge clk_i) begin
    tok_event_t exp_ev;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (events_due.size() == 0) report_mismatch("unexpected event", m_axis_tdata[3:0], 0);
        else begin
          exp_ev = events_due.pop_front();
          if (m_axis_tdata[3:0] != exp_ev.kind)
            report_mismatch("event_kind", m_axis_tdata[3:0], exp_ev.kind);
          if (m_axis_tdata[35:4] != exp_ev.span_start)
            report_mismatch("span_start", m_axis_tdata[35:4], exp_ev.span_start);
          if (m_axis_tdata[67:36] != exp_ev.span_len)
            report_mismatch("span_length", m_axis_tdata[67:36], exp_ev.span_len);
          if (m_axis_tdata[99:68] != exp_ev.val_start)
            report_mismatch("value_start", m_axis_tdata[99:68], exp_ev.val_start);
          if (m_axis_tdata[131:100] != exp_ev.val_len)
            report_mismatch("value_length", m_axis_tdata[131:100], exp_ev.val_len);
          if (m_axis_tdata[132] != exp_ev.ws_only)
            report_mismatch("whitespace_only", m_axis_tdata[132], exp_ev.ws_only);
          if (m_axis_tlast != exp_ev.fin)
            report_mismatch("final_result", m_axis_tlast, exp_ev.fin);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tokenize_unit(s_axis_tdata, s_axis_tlast);
        // directed rows carry a kind that is obvious from the input
        if (doc_q[taken_idx].chk && (burst.size() == 0 || burst[0].kind != doc_q[taken_idx].k))
          report_mismatch("directed kind", burst.size() ? burst[0].kind : 4'hF,
                          doc_q[taken_idx].k);
        taken_idx++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else if (++idle_cycles >= IDLE_LIMIT) begin
        $display("xml_sax_tokenizer verification failed");
        $finish;
      end
    end
  end

  // Receiver: stall at the rate of the current phase.
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= rcv_pct);
  end

  initial begin
    errors = 0;
    taken_idx = 0;
    idle_cycles = 0;
    snd_pct = 0;
    rcv_pct = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    pst = xst_pkg::S_READY;
    ekind = xst_pkg::K_TAG;
    {depth, qch, pos, tmark, nms, nme, ams, ame, dms, dparts, kidx, thist} = '0;
    allsp = 1'b1;
    err_seen = 1'b0;
    build_document();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (sent_idx = 0; sent_idx < doc_q.size(); sent_idx++) begin
      case (sent_idx * 4 / doc_q.size())
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 49; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 49; end
        default: begin snd_pct = 38; rcv_pct = 38; end
      endcase
      if (sent_idx == doc_q.size() / 2) begin
        // hold the sender until the event stream has drained
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (events_due.size() != 0);
        @(posedge clk_i);
      end
      while ($urandom_range(0, 99) < snd_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= doc_q[sent_idx].u;
      s_axis_tlast <= doc_q[sent_idx].last;
      do @(posedge clk_i); while (!s_axis_tready);
    end
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (events_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("xml_sax_tokenizer verification clean");
    else $display("xml_sax_tokenizer verification failed");
    $finish;
  end

endmodule

/* filelist.f */
sv/xst_pkg.sv
sv/xst_parser.sv
sv/xst_backend.sv
sv/xml_sax_tokenizer.sv
dv/tb_xml_sax_tokenizer.sv
